### sv/sfid_pkg.sv
// Shared constants and controller/datapath interface types of the identifier allocator.
`default_nettype none

package sfid_pkg;

    localparam int MAX_IDS_DEFAULT = 64;
    localparam int ID_W            = 6;
    localparam int ST_W            = 2;

    localparam logic [ST_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [ST_W-1:0] STATUS_NONE_LEFT = 2'd1;
    localparam logic [ST_W-1:0] STATUS_HEAP_FULL = 2'd2;

    typedef struct packed {
        logic accept;       // latch the request word
        logic grant_fresh;  // grant the fresh counter, advance it
        logic set_none;     // result: no identifier left
        logic set_full;     // result: release dropped
        logic rel_start;    // start insertion at the heap tail
        logic al_rd;        // read root and last entry
        logic al_take;      // grant the root, lift last entry into the hole
        logic sd_rd;        // read both children of the hole
        logic sd_step;      // move a child up or settle the value
        logic su_rd;        // read the parent of the hole
        logic su_step;      // move the parent down or settle the value
        logic su_root;      // settle the value at the root
        logic push;         // load the result into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic op_release;
        logic heap_empty;
        logic heap_full;
        logic fresh_left;
        logic last_one;
        logic pos_zero;
        logic sd_move;
        logic su_move;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### sv/smallest_free_id_allocator.sv
// Top level of the smallest-free identifier allocator: controller plus datapath.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one word: operation (0 allocate,
//   1 release) and release_id. Response channel (rsp_valid/rsp_ready) returns one
//   word per request: granted_id and status (0 ok, 1 no identifier left, 2 release
//   dropped because the heap is full).
//   Released identifiers sit in a min-heap held in a dual-read RAM; an allocate
//   takes the root, or the next never-used identifier when the heap is empty.
//   Requests are handled one at a time; req_ready is high only while idle.
//   Each request runs through the controller steps from accept to result loaded: a
//   fresh grant, an exhausted allocate or a dropped release go straight from decide
//   to the result; a heap allocate reads root and last entry, then sifts down when
//   more than one entry was held; a release climbs from the tail, settling below or
//   at the root. With 64 identifiers the slowest request is a release climbing six
//   levels; the sift walk over the heap RAM does one read and one compare-write per
//   level. The response sits in an output register; a stalled receiver holds it,
//   and a finished request waits for the register to free.
//   Reset empties the heap and zeroes the fresh counter; heap RAM is not cleared,
//   only entries below the heap count are ever used.
`default_nettype none

module smallest_free_id_allocator #(
    parameter int MAX_IDS = sfid_pkg::MAX_IDS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire logic                      operation,
    input  wire logic [sfid_pkg::ID_W-1:0] release_id,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output logic      [sfid_pkg::ID_W-1:0] granted_id,
    output logic      [sfid_pkg::ST_W-1:0] status
);
    import sfid_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequence each request through decide, read and sift steps
    sfid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // hold heap, counters and the response word
    sfid_dp #(
        .MAX_IDS (MAX_IDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .operation  (operation),
        .release_id (release_id),
        .rsp_ready  (rsp_ready),
        .rsp_valid  (rsp_valid),
        .granted_id (granted_id),
        .status     (status)
    );

endmodule

`default_nettype wire

### sv/sfid_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module sfid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wa,
    input  wire logic [WIDTH-1:0] wd,
    input  wire logic [AW-1:0]    ra0,
    input  wire logic [AW-1:0]    ra1,
    output logic      [WIDTH-1:0] rd0,
    output logic      [WIDTH-1:0] rd1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd0 <= mem[ra0];
        rd1 <= mem[ra1];
    end

endmodule

`default_nettype wire

### sv/sfid_ctrl.sv
// Controller state machine of the identifier allocator.
`default_nettype none

module sfid_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire sfid_pkg::dp_stat_t   stat,
    output sfid_pkg::ctrl_cmd_t       cmd
);
    import sfid_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECIDE = 10'b0000000010,
        S_AL_RD  = 10'b0000000100,
        S_AL_EV  = 10'b0000001000,
        S_SD_RD  = 10'b0000010000,
        S_SD_EV  = 10'b0000100000,
        S_SU_CHK = 10'b0001000000,
        S_SU_EV  = 10'b0010000000,
        S_PUSH   = 10'b0100000000,
        S_SU_RD  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!stat.op_release)
                begin
                    if (!stat.heap_empty)
                    begin
                        state_next = S_AL_RD;
                    end
                    else if (stat.fresh_left)
                    begin
                        cmd.grant_fresh = 1'b1;
                        state_next      = S_PUSH;
                    end
                    else
                    begin
                        cmd.set_none = 1'b1;
                        state_next   = S_PUSH;
                    end
                end
                else if (stat.heap_full)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = S_PUSH;
                end
                else
                begin
                    cmd.rel_start = 1'b1;
                    state_next    = S_SU_CHK;
                end
            end
            S_AL_RD:
            begin
                cmd.al_rd  = 1'b1;
                state_next = S_AL_EV;
            end
            S_AL_EV:
            begin
                cmd.al_take = 1'b1;
                state_next  = stat.last_one ? S_PUSH : S_SD_RD;
            end
            S_SD_RD:
            begin
                cmd.sd_rd  = 1'b1;
                state_next = S_SD_EV;
            end
            S_SD_EV:
            begin
                cmd.sd_step = 1'b1;
                state_next  = stat.sd_move ? S_SD_RD : S_PUSH;
            end
            S_SU_CHK:
            begin
                if (stat.pos_zero)
                begin
                    cmd.su_root = 1'b1;
                    state_next  = S_PUSH;
                end
                else
                begin
                    state_next = S_SU_RD;
                end
            end
            S_SU_RD:
            begin
                cmd.su_rd  = 1'b1;
                state_next = S_SU_EV;
            end
            S_SU_EV:
            begin
                cmd.su_step = 1'b1;
                state_next  = stat.su_move ? S_SU_CHK : S_PUSH;
            end
            S_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### sv/sfid_dp.sv
// Datapath of the identifier allocator: heap memory, counters, hole position, result word.
`default_nettype none

module sfid_dp #(
    parameter int MAX_IDS = sfid_pkg::MAX_IDS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sfid_pkg::ctrl_cmd_t           cmd,
    output sfid_pkg::dp_stat_t                 stat,
    input  wire logic                          operation,
    input  wire logic [sfid_pkg::ID_W-1:0]     release_id,
    input  wire logic                          rsp_ready,
    output logic                               rsp_valid,
    output logic      [sfid_pkg::ID_W-1:0]     granted_id,
    output logic      [sfid_pkg::ST_W-1:0]     status
);
    import sfid_pkg::*;

    localparam int AW = $clog2(MAX_IDS);
    localparam int CW = $clog2(MAX_IDS + 1);
    localparam int LW = AW + 2;
    localparam int GW = (CW > ID_W) ? CW : ID_W;

    // control state
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   fresh_reg, fresh_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // payload
    logic            op_reg, op_next;
    logic [ID_W-1:0] rid_reg, rid_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [ID_W-1:0] v_reg, v_next;
    logic [ID_W-1:0] res_id_reg, res_id_next;
    logic [ST_W-1:0] res_st_reg, res_st_next;
    logic [ID_W-1:0] granted_reg, granted_next;
    logic [ST_W-1:0] status_reg, status_next;

    // heap memory ports
    logic            we;
    logic [AW-1:0]   wa;
    logic [ID_W-1:0] wd;
    logic [AW-1:0]   ra0, ra1;
    logic [ID_W-1:0] rd0, rd1;

    // index arithmetic
    logic [LW-1:0]   lc_ext, rc_ext, cnt_ext;
    logic            lc_in, rc_in, lc_less, rc_less;
    logic [AW-1:0]   pos_m1, parent;
    logic [CW-1:0]   cnt_m1;
    logic [GW-1:0]   fresh_wide;
    logic [AW-1:0]   best_idx;
    logic [ID_W-1:0] best_val;
    logic            sd_move, su_move;

    sfid_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_IDS),
        .AW    (AW)
    ) u_heap (
        .clk (clk),
        .we  (we),
        .wa  (wa),
        .wd  (wd),
        .ra0 (ra0),
        .ra1 (ra1),
        .rd0 (rd0),
        .rd1 (rd1)
    );

    assign lc_ext     = LW'({pos_reg, 1'b1});
    assign rc_ext     = LW'({pos_reg, 1'b0}) + LW'(2);
    assign cnt_ext    = LW'(count_reg);
    assign lc_in      = lc_ext < cnt_ext;
    assign rc_in      = rc_ext < cnt_ext;
    assign pos_m1     = pos_reg - AW'(1);
    assign parent     = pos_m1 >> 1;
    assign cnt_m1     = count_reg - CW'(1);
    assign fresh_wide = GW'(fresh_reg);

    // Strict compares; the left child wins a tie.
    assign lc_less = lc_in && (rd0 < v_reg);
    assign rc_less = rc_in && (rd1 < (lc_less ? rd0 : v_reg));
    assign sd_move = lc_less || rc_less;
    assign su_move = rd0 > v_reg;

    always_comb
    begin
        if (rc_less)
        begin
            best_idx = rc_ext[AW-1:0];
            best_val = rd1;
        end
        else
        begin
            best_idx = lc_ext[AW-1:0];
            best_val = rd0;
        end
    end

    // memory addressing
    always_comb
    begin
        ra0 = '0;
        ra1 = '0;
        if (cmd.al_rd)
        begin
            ra0 = '0;
            ra1 = cnt_m1[AW-1:0];
        end
        else if (cmd.sd_rd)
        begin
            ra0 = lc_ext[AW-1:0];
            ra1 = rc_ext[AW-1:0];
        end
        else if (cmd.su_rd)
        begin
            ra0 = parent;
        end

        we = cmd.sd_step || cmd.su_step || cmd.su_root;
        wa = pos_reg;
        wd = v_reg;
        if (cmd.sd_step && sd_move)
        begin
            wd = best_val;
        end
        else if (cmd.su_step && su_move)
        begin
            wd = rd0;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        fresh_next     = fresh_reg;
        rsp_valid_next = rsp_valid_reg;
        op_next        = op_reg;
        rid_next       = rid_reg;
        pos_next       = pos_reg;
        v_next         = v_reg;
        res_id_next    = res_id_reg;
        res_st_next    = res_st_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cmd.accept)
        begin
            op_next  = operation;
            rid_next = release_id;
        end
        if (cmd.grant_fresh)
        begin
            res_id_next = fresh_wide[ID_W-1:0];
            res_st_next = STATUS_OK;
            fresh_next  = fresh_reg + CW'(1);
        end
        if (cmd.set_none)
        begin
            res_id_next = '0;
            res_st_next = STATUS_NONE_LEFT;
        end
        if (cmd.set_full)
        begin
            res_id_next = '0;
            res_st_next = STATUS_HEAP_FULL;
        end
        if (cmd.rel_start)
        begin
            res_id_next = '0;
            res_st_next = STATUS_OK;
            v_next      = rid_reg;
            pos_next    = count_reg[AW-1:0];
            count_next  = count_reg + CW'(1);
        end
        if (cmd.al_take)
        begin
            res_id_next = rd0;
            res_st_next = STATUS_OK;
            v_next      = rd1;
            pos_next    = '0;
            count_next  = cnt_m1;
        end
        if (cmd.sd_step && sd_move)
        begin
            pos_next = best_idx;
        end
        if (cmd.su_step && su_move)
        begin
            pos_next = parent;
        end
        if (cmd.push)
        begin
            rsp_valid_next = 1'b1;
            granted_next   = res_id_reg;
            status_next    = res_st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fresh_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        rid_reg     <= rid_next;
        pos_reg     <= pos_next;
        v_reg       <= v_next;
        res_id_reg  <= res_id_next;
        res_st_reg  <= res_st_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    assign stat.op_release = op_reg;
    assign stat.heap_empty = (count_reg == '0);
    assign stat.heap_full  = (count_reg == CW'(MAX_IDS));
    assign stat.fresh_left = (fresh_reg < CW'(MAX_IDS));
    assign stat.last_one   = (count_reg == CW'(1));
    assign stat.pos_zero   = (pos_reg == '0);
    assign stat.sd_move    = sd_move;
    assign stat.su_move    = su_move;
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid  = rsp_valid_reg;
    assign granted_id = granted_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the smallest-free identifier allocator.
`timescale 1ns / 100ps

// Operation codes of the request word.
localparam logic OP_ALLOCATE = 1'b0;
localparam logic OP_RELEASE  = 1'b1;

// One expected response word, plus whether it came from an allocate.
typedef struct packed {
    logic                      from_allocate;
    logic [sfid_pkg::ID_W-1:0] granted_id;
    logic [sfid_pkg::ST_W-1:0] status;
} grant_word_t;

// Keeps its own copy of the free-id heap and the fresh counter, predicts the
// response of every accepted request and checks responses in order.
class grant_scoreboard;
    grant_word_t               pending_grants[$];
    logic [sfid_pkg::ID_W-1:0] free_heap[sfid_pkg::MAX_IDS_DEFAULT];
    int                        heap_size;
    int                        next_fresh;
    int                        mismatches;

    function new();
        heap_size  = 0;
        next_fresh = 0;
        mismatches = 0;
    endfunction

    // Predict the response of an accepted request and queue it.
    function void note_request(logic op, logic [sfid_pkg::ID_W-1:0] rid);
        grant_word_t               g;
        logic [sfid_pkg::ID_W-1:0] tmp;
        int                        pos;
        int                        up;
        int                        lc;
        int                        rc;
        int                        best;
        bit                        settled;
        g.from_allocate = (op == OP_ALLOCATE);
        g.granted_id    = '0;
        g.status        = sfid_pkg::STATUS_OK;
        if (op == OP_ALLOCATE) begin
            if (heap_size > 0) begin
                // Take the root, lift the tail into the hole, sift down.
                g.granted_id = free_heap[0];
                heap_size--;
                if (heap_size > 0) begin
                    free_heap[0] = free_heap[heap_size];
                    pos     = 0;
                    settled = 1'b0;
                    while (!settled) begin
                        lc   = 2 * pos + 1;
                        rc   = 2 * pos + 2;
                        best = pos;
                        // strict compares: the left child wins a tie
                        if (lc < heap_size && free_heap[lc] < free_heap[best])
                            best = lc;
                        if (rc < heap_size && free_heap[rc] < free_heap[best])
                            best = rc;
                        if (best == pos) begin
                            settled = 1'b1;
                        end
                        else begin
                            tmp             = free_heap[best];
                            free_heap[best] = free_heap[pos];
                            free_heap[pos]  = tmp;
                            pos             = best;
                        end
                    end
                end
            end
            else if (next_fresh < sfid_pkg::MAX_IDS_DEFAULT) begin
                g.granted_id = sfid_pkg::ID_W'(next_fresh);
                next_fresh++;
            end
            else begin
                g.status = sfid_pkg::STATUS_NONE_LEFT;
            end
        end
        else if (heap_size >= sfid_pkg::MAX_IDS_DEFAULT) begin
            g.status = sfid_pkg::STATUS_HEAP_FULL;
        end
        else begin
            // Append at the tail and sift up on strictly smaller keys.
            free_heap[heap_size] = rid;
            pos     = heap_size;
            settled = 1'b0;
            while (pos > 0 && !settled) begin
                up = (pos - 1) / 2;
                if (free_heap[up] > free_heap[pos]) begin
                    tmp            = free_heap[up];
                    free_heap[up]  = free_heap[pos];
                    free_heap[pos] = tmp;
                    pos            = up;
                end
                else begin
                    settled = 1'b1;
                end
            end
            heap_size++;
        end
        pending_grants.push_back(g);
    endfunction

    // Check a response against the oldest prediction; return 1 when it
    // handed out an identifier.
    function bit check_grant(logic [sfid_pkg::ID_W-1:0] gid, logic [sfid_pkg::ST_W-1:0] st);
        grant_word_t g;
        if (pending_grants.size() == 0) begin
            $error("response word with no request outstanding: granted_id %0d status %0d",
                   gid, st);
            mismatches++;
            return 1'b0;
        end
        g = pending_grants.pop_front();
        if (gid !== g.granted_id) begin
            $error("granted_id: expected %0d, actual %0d", g.granted_id, gid);
            mismatches++;
        end
        if (st !== g.status) begin
            $error("status: expected %0d, actual %0d", g.status, st);
            mismatches++;
        end
        return g.from_allocate && (g.status == sfid_pkg::STATUS_OK);
    endfunction
endclass

module testbench;

    // Cycles with no word moving on either channel before the run is given up.
    // It is well above the slowest item plus the longest sender gap and
    // receiver stall.
    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 500;
    localparam int ID_COUNT     = sfid_pkg::MAX_IDS_DEFAULT;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      req_valid  = 1'b0;
    logic                      operation  = OP_ALLOCATE;
    logic [sfid_pkg::ID_W-1:0] release_id = '0;
    logic                      rsp_ready  = 1'b0;
    wire                       req_ready;
    wire                       rsp_valid;
    wire  [sfid_pkg::ID_W-1:0] granted_id;
    wire  [sfid_pkg::ST_W-1:0] status;

    grant_scoreboard           sb;
    logic [sfid_pkg::ID_W-1:0] lent_ids[$];   // ids handed out, candidates to give back
    int                        burst_left = 0;
    int                        words_sent = 0;
    int                        quiet_cycles = 0;

    smallest_free_id_allocator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .operation  (operation),
        .release_id (release_id),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .granted_id (granted_id),
        .status     (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Send one request word. The sender works in bursts: at the start of a
    // burst drop valid for a random gap, then hold valid and payload until
    // the word is taken. Valid is left high so the next word of the burst
    // follows back to back.
    task automatic issue(input logic op, input logic [sfid_pkg::ID_W-1:0] rid);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap != 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid  <= 1'b1;
        operation  <= op;
        release_id <= rid;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sb.note_request(op, rid);
        words_sent++;
    endtask

    // Hold the sender off until every outstanding response has come back.
    task automatic drain_all();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_grants.size() != 0) @(posedge clk);
    endtask

    // Release either an id that is out on loan (well-formed use) or, now and
    // then, any id at all, which exercises duplicates and never-granted ids.
    task automatic give_back();
        int idx;
        logic [sfid_pkg::ID_W-1:0] rid;
        if (lent_ids.size() != 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, lent_ids.size() - 1);
            rid = lent_ids[idx];
            lent_ids.delete(idx);
        end
        else begin
            rid = sfid_pkg::ID_W'($urandom_range(0, ID_COUNT - 1));
        end
        issue(OP_RELEASE, rid);
    endtask

    // Receiver: check every response word as it is taken, and drive the
    // ready line from an eight-bit stall pattern that the loop re-draws. Some
    // draws take every word with no stall at all.
    initial
    begin : response_side
        logic [7:0] stall_pattern;
        int         cyc;
        stall_pattern = 8'hFF;
        cyc           = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready) begin
                if (sb.check_grant(granted_id, status))
                    lent_ids.push_back(granted_id);
            end
            if (cyc % 48 == 0) begin
                if ($urandom_range(0, 3) == 0)
                    stall_pattern = 8'hFF;
                else
                    stall_pattern = 8'($urandom_range(0, 255)) | (8'h01 << $urandom_range(0, 7));
            end
            rsp_ready <= rst_n && stall_pattern[cyc % 8];
            cyc++;
        end
    end

    // Count cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int mode;
        int len;
        int alloc_odds;
        sb = new();

        // Hold reset low at the start, then release it once.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words: fresh grants with release_id at its extremes (it
        // must be ignored), duplicate releases, equal keys in the heap so the
        // sift walks meet ties, then allocates that empty the heap once more.
        issue(OP_ALLOCATE, 6'd63);
        issue(OP_ALLOCATE, 6'd0);
        issue(OP_RELEASE,  6'd63);
        issue(OP_RELEASE,  6'd0);
        issue(OP_RELEASE,  6'd0);
        issue(OP_RELEASE,  6'd5);
        issue(OP_RELEASE,  6'd5);
        repeat (6) issue(OP_ALLOCATE, 6'd42);
        issue(OP_RELEASE,  6'd1);
        issue(OP_RELEASE,  6'd1);
        issue(OP_RELEASE,  6'd1);
        issue(OP_RELEASE,  6'd2);
        issue(OP_RELEASE,  6'd42);
        issue(OP_RELEASE,  6'd21);
        drain_all();
        repeat (6) issue(OP_ALLOCATE, 6'd21);

        // Fill the heap past its size so the last releases are dropped.
        repeat (ID_COUNT + 4) issue(OP_RELEASE, sfid_pkg::ID_W'($urandom_range(0, ID_COUNT - 1)));
        // Empty the heap, use up every fresh id, then run into exhaustion.
        repeat (2 * ID_COUNT + 8)
            issue(OP_ALLOCATE, sfid_pkg::ID_W'($urandom_range(0, ID_COUNT - 1)));
        drain_all();
        lent_ids.delete();

        // Random episodes, each leaning toward allocate, release, or neither.
        // Most releases hand back ids that are out on loan.
        while (words_sent < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(20, 60);
            alloc_odds = (mode == 0) ? 80 : ((mode == 1) ? 20 : 50);
            if ($urandom_range(0, 3) == 0)
                drain_all();
            repeat (len)
            begin
                if ($urandom_range(0, 99) < alloc_odds)
                    issue(OP_ALLOCATE, sfid_pkg::ID_W'($urandom_range(0, ID_COUNT - 1)));
                else
                    give_back();
            end
        end

        // Drop valid, wait out the outstanding responses and a short tail.
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_grants.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_grants.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
